/* sv/tcpqa_pkg.sv */
// ----------------------------------------------------------------------------
// tcpqa_pkg: shared types and constants of the two-class priority scheduler
// Command codes, service outcomes, statistic selects and queue geometry.
// ----------------------------------------------------------------------------
package tcpqa_pkg;

    // Queue geometry.
    localparam int QUEUE_DEPTH = 16;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int FILL_W      = 5;
    localparam int ID_W        = 16;
    localparam int TIME_W      = 32;
    localparam int CNT_W       = 32;
    localparam int SUM_W       = 48;
    localparam int NUM_EVT     = 8;

    // Saturation limits.
    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    // Reset value of the depth cap register.
    localparam logic [FILL_W-1:0] LIMIT_RESET = FILL_W'(QUEUE_DEPTH);

    // Configuration register indexes.
    localparam logic REG_DEPTH_CAP = 1'b0;

    // Command codes.
    typedef enum logic [1:0] {
        CMD_ENQ_HIGH = 2'd0,
        CMD_ENQ_LOW  = 2'd1,
        CMD_SERVICE  = 2'd2,
        CMD_READ     = 2'd3
    } t_cmd;

    // Service outcome codes.
    typedef enum logic [1:0] {
        ACT_IDLE = 2'd0,
        ACT_HIGH = 2'd1,
        ACT_LOW  = 2'd2,
        ACT_RSVD = 2'd3
    } t_activity;

    // Event counter slots.
    localparam int EVT_HIGH_REQ = 0;
    localparam int EVT_LOW_REQ  = 1;
    localparam int EVT_HIGH_ACC = 2;
    localparam int EVT_LOW_ACC  = 3;
    localparam int EVT_HIGH_REF = 4;
    localparam int EVT_LOW_REF  = 5;
    localparam int EVT_HIGH_SRV = 6;
    localparam int EVT_LOW_SRV  = 7;

    // Statistic selects beyond the event counters.
    localparam logic [3:0] STAT_HIGH_WSUM = 4'd8;
    localparam logic [3:0] STAT_LOW_WSUM  = 4'd9;
    localparam logic [3:0] STAT_IDLE      = 4'd10;

    // One queued entry.
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] start;
    } t_entry;

endpackage

/* sv/two_class_priority_queue_arbiter_top.sv */
// ----------------------------------------------------------------------------
// two_class_priority_queue_arbiter_top: strict-priority two-queue scheduler
// Two bounded FIFOs with tail drop, strict-priority service, saturating
// statistics and an APB-style register for the depth cap.
// ----------------------------------------------------------------------------
// Usage: the block takes one command in every clock cycle; busy is never
// high. A command is captured in an input register at the edge that accepts
// it and executed in the following cycle by a single pass of logic that
// updates the queues and counters. Its result word is registered at the next
// edge and shown for one cycle, marked by o_done. Every command, including
// reads, produces exactly one result word. The receiver cannot stall the
// block, so results must be taken in the cycle they are shown.
// The user must write the depth cap through the configuration port only
// while no command is in flight; the block itself does not enforce this.
module two_class_priority_queue_arbiter_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Command channel.
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_cmd,
    input  logic [tcpqa_pkg::ID_W-1:0]    i_entry_id,
    input  logic [tcpqa_pkg::TIME_W-1:0]  i_time_value,
    input  logic [3:0]                    i_stat_select,
    // Result channel.
    output logic                          o_done,
    output logic                          o_status,
    output logic [1:0]                    o_activity,
    output logic [tcpqa_pkg::ID_W-1:0]    o_served_id,
    output logic [tcpqa_pkg::TIME_W-1:0]  o_served_start,
    output logic [tcpqa_pkg::TIME_W-1:0]  o_wait_time,
    output logic [tcpqa_pkg::SUM_W-1:0]   o_stat_value,
    output logic [tcpqa_pkg::FILL_W-1:0]  o_high_fill,
    output logic [tcpqa_pkg::FILL_W-1:0]  o_low_fill,
    // Configuration port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import tcpqa_pkg::*;

    // Input register.
    logic              r_in_valid;
    t_cmd              r_cmd;
    logic [ID_W-1:0]   r_id;
    logic [TIME_W-1:0] r_time;
    logic [3:0]        r_sel;

    // Configuration.
    logic [FILL_W-1:0] r_depth_cap;

    // Queue state.
    t_entry            r_high_store [QUEUE_DEPTH];
    t_entry            r_low_store  [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_high_head, n_high_head;
    logic [PTR_W-1:0]  r_low_head,  n_low_head;
    logic [FILL_W-1:0] r_high_cnt,  n_high_cnt;
    logic [FILL_W-1:0] r_low_cnt,   n_low_cnt;

    // Statistics.
    logic [CNT_W-1:0]  r_evt_cnt [NUM_EVT];
    logic [CNT_W-1:0]  n_evt_cnt [NUM_EVT];
    logic [SUM_W-1:0]  r_high_wsum, n_high_wsum;
    logic [SUM_W-1:0]  r_low_wsum,  n_low_wsum;
    logic [CNT_W-1:0]  r_idle,      n_idle;

    // Single-pass datapath signals.
    logic [FILL_W-1:0] eff_limit;
    logic              enq_high, enq_low, serve;
    logic              high_full, low_full;
    logic              push_high, push_low;
    logic              pop_high, pop_low, idle_slot;
    logic [PTR_W-1:0]  high_tail, low_tail;
    t_entry            head_entry;
    logic [TIME_W-1:0] wait_val;
    logic [SUM_W-1:0]  wait_ext;
    logic [NUM_EVT-1:0] evt_inc;
    logic [SUM_W-1:0]  stat_val;
    logic              cfg_write;

    // Tail position of a ring, wrapping at the queue depth.
    function automatic logic [PTR_W-1:0] ring_tail(
        input logic [PTR_W-1:0]  head,
        input logic [FILL_W-1:0] cnt
    );
        logic [PTR_W+FILL_W-1:0] pos;
        pos = (PTR_W+FILL_W)'(head) + (PTR_W+FILL_W)'(cnt);
        if (pos >= (PTR_W+FILL_W)'(QUEUE_DEPTH)) begin
            pos = pos - (PTR_W+FILL_W)'(QUEUE_DEPTH);
        end
        return pos[PTR_W-1:0];
    endfunction

    // Head pointer after a pop.
    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] ptr);
        return (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
    endfunction

    // Saturating add of a wait to a wait sum.
    function automatic logic [SUM_W-1:0] sum_sat(
        input logic [SUM_W-1:0] sum,
        input logic [SUM_W-1:0] val
    );
        return (val >= SUM_MAX - sum) ? SUM_MAX : sum + val;
    endfunction

    // The block never stalls a command or a register access.
    assign busy   = 1'b0;
    assign pready = 1'b1;

    // Register write strobe and readback.
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_DEPTH_CAP) ? {{(32-FILL_W){1'b0}}, r_depth_cap}
                                                   : 32'd0;

    // Decode the registered command against the current queue state.
    always_comb begin
        eff_limit = (r_depth_cap > FILL_W'(QUEUE_DEPTH)) ? FILL_W'(QUEUE_DEPTH)
                                                         : r_depth_cap;
        enq_high  = r_in_valid && (r_cmd == CMD_ENQ_HIGH);
        enq_low   = r_in_valid && (r_cmd == CMD_ENQ_LOW);
        serve     = r_in_valid && (r_cmd == CMD_SERVICE);
        high_full = r_high_cnt >= eff_limit;
        low_full  = r_low_cnt >= eff_limit;
        push_high = enq_high && !high_full;
        push_low  = enq_low && !low_full;
        pop_high  = serve && (r_high_cnt != '0);
        pop_low   = serve && (r_high_cnt == '0) && (r_low_cnt != '0);
        idle_slot = serve && (r_high_cnt == '0) && (r_low_cnt == '0);
        high_tail = ring_tail(r_high_head, r_high_cnt);
        low_tail  = ring_tail(r_low_head, r_low_cnt);
        head_entry = pop_high ? r_high_store[r_high_head] : r_low_store[r_low_head];
        wait_val  = r_time - head_entry.start;
        wait_ext  = SUM_W'(wait_val);
    end

    // Next queue pointers and fills.
    always_comb begin
        n_high_head = pop_high ? ring_next(r_high_head) : r_high_head;
        n_low_head  = pop_low  ? ring_next(r_low_head)  : r_low_head;
        n_high_cnt  = r_high_cnt;
        n_low_cnt   = r_low_cnt;
        if (push_high) begin
            n_high_cnt = r_high_cnt + FILL_W'(1);
        end else if (pop_high) begin
            n_high_cnt = r_high_cnt - FILL_W'(1);
        end
        if (push_low) begin
            n_low_cnt = r_low_cnt + FILL_W'(1);
        end else if (pop_low) begin
            n_low_cnt = r_low_cnt - FILL_W'(1);
        end
    end

    // Event counter increments and saturating updates.
    always_comb begin
        evt_inc               = '0;
        evt_inc[EVT_HIGH_REQ] = enq_high;
        evt_inc[EVT_LOW_REQ]  = enq_low;
        evt_inc[EVT_HIGH_ACC] = push_high;
        evt_inc[EVT_LOW_ACC]  = push_low;
        evt_inc[EVT_HIGH_REF] = enq_high && high_full;
        evt_inc[EVT_LOW_REF]  = enq_low && low_full;
        evt_inc[EVT_HIGH_SRV] = pop_high;
        evt_inc[EVT_LOW_SRV]  = pop_low;
        for (int k = 0; k < NUM_EVT; k++) begin
            n_evt_cnt[k] = (evt_inc[k] && (r_evt_cnt[k] != CNT_MAX))
                         ? r_evt_cnt[k] + CNT_W'(1) : r_evt_cnt[k];
        end
        n_idle      = (idle_slot && (r_idle != CNT_MAX)) ? r_idle + CNT_W'(1) : r_idle;
        n_high_wsum = pop_high ? sum_sat(r_high_wsum, wait_ext) : r_high_wsum;
        n_low_wsum  = pop_low  ? sum_sat(r_low_wsum, wait_ext)  : r_low_wsum;
    end

    // Statistic readback selection.
    always_comb begin
        stat_val = '0;
        if (r_sel[3] == 1'b0) begin
            stat_val = SUM_W'(r_evt_cnt[r_sel[2:0]]);
        end else begin
            case (r_sel)
                STAT_HIGH_WSUM: stat_val = r_high_wsum;
                STAT_LOW_WSUM:  stat_val = r_low_wsum;
                STAT_IDLE:      stat_val = SUM_W'(r_idle);
                default:        stat_val = '0;
            endcase
        end
    end

    // Control state, statistics and result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_depth_cap   <= LIMIT_RESET;
            r_high_head   <= '0;
            r_low_head    <= '0;
            r_high_cnt    <= '0;
            r_low_cnt     <= '0;
            r_high_wsum   <= '0;
            r_low_wsum    <= '0;
            r_idle        <= '0;
            for (int k = 0; k < NUM_EVT; k++) begin
                r_evt_cnt[k] <= '0;
            end
            o_done        <= 1'b0;
        end else begin
            r_in_valid  <= start && !busy;
            if (cfg_write && (paddr[2] == REG_DEPTH_CAP)) begin
                r_depth_cap <= pwdata[FILL_W-1:0];
            end
            r_high_head <= n_high_head;
            r_low_head  <= n_low_head;
            r_high_cnt  <= n_high_cnt;
            r_low_cnt   <= n_low_cnt;
            r_high_wsum <= n_high_wsum;
            r_low_wsum  <= n_low_wsum;
            r_idle      <= n_idle;
            for (int k = 0; k < NUM_EVT; k++) begin
                r_evt_cnt[k] <= n_evt_cnt[k];
            end
            o_done      <= r_in_valid;
        end
    end

    // Input word capture.
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_cmd  <= t_cmd'(i_cmd);
            r_id   <= i_entry_id;
            r_time <= i_time_value;
            r_sel  <= i_stat_select;
        end
    end

    // Queue storage writes at the tail.
    always_ff @(posedge i_clk) begin
        if (push_high) begin
            r_high_store[high_tail] <= '{id: r_id, start: r_time};
        end
        if (push_low) begin
            r_low_store[low_tail] <= '{id: r_id, start: r_time};
        end
    end

    // Result word register.
    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            o_status       <= (enq_high && high_full) || (enq_low && low_full);
            o_activity     <= pop_high ? ACT_HIGH : (pop_low ? ACT_LOW : ACT_IDLE);
            o_served_id    <= (pop_high || pop_low) ? head_entry.id : '0;
            o_served_start <= (pop_high || pop_low) ? head_entry.start : '0;
            o_wait_time    <= (pop_high || pop_low) ? wait_val : '0;
            o_stat_value   <= (r_cmd == CMD_READ) ? stat_val : '0;
            o_high_fill    <= n_high_cnt;
            o_low_fill     <= n_low_cnt;
        end
    end

    // A queue never holds more entries than its depth.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_high_cnt <= FILL_W'(QUEUE_DEPTH)) && (r_low_cnt <= FILL_W'(QUEUE_DEPTH)))
        else $error("queue fill exceeds depth");

    // Every accepted command produces its result word, marked by o_done.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_done)
        else $error("result word missing for accepted command");

    // Reported fills match the queue state left by the command.
    a_fill_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ((o_high_fill == r_high_cnt) && (o_low_fill == r_low_cnt)))
        else $error("reported fill disagrees with queue state");

    // The low queue is served only when the high queue is empty.
    a_strict_priority: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_activity == ACT_LOW)) |-> (o_high_fill == '0))
        else $error("low queue served while high queue held entries");

    // A refused enqueue never coincides with a service outcome.
    a_refuse_no_serve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status) |-> (o_activity == ACT_IDLE))
        else $error("refusal reported together with a served entry");

endmodule

/* test/two_class_priority_queue_arbiter_top_tb.sv */
// ----------------------------------------------------------------------------
// two_class_priority_queue_arbiter_top_tb: self-checking bench for the scheduler
// Commands go in through a backlog and a falling-edge driver with random
// gaps. A rising-edge monitor predicts each result word in a model of the two
// queues and the saturating statistics, then checks every field when the
// word comes back. The depth cap register moves through several settings,
// zero and values above the depth among them.
// ----------------------------------------------------------------------------
module two_class_priority_queue_arbiter_top_tb;
    import tcpqa_pkg::*;

    localparam logic [2:0] LIMIT_ADDR = {REG_DEPTH_CAP, 2'b00};

    // One command word as sent to the block.
    typedef struct {
        t_cmd              cmd;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] tval;
        logic [3:0]        sel;
    } t_sched_cmd;

    // One result word as returned by the block.
    typedef struct {
        logic              status;
        t_activity         act;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] srv_start;
        logic [TIME_W-1:0] wait_cycles;
        logic [SUM_W-1:0]  stat;
        logic [FILL_W-1:0] hi_fill;
        logic [FILL_W-1:0] lo_fill;
    } t_sched_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [1:0] i_cmd = '0;
    logic [ID_W-1:0] i_entry_id = '0;
    logic [TIME_W-1:0] i_time_value = '0;
    logic [3:0] i_stat_select = '0;
    logic o_done;
    logic o_status;
    logic [1:0] o_activity;
    logic [ID_W-1:0] o_served_id;
    logic [TIME_W-1:0] o_served_start;
    logic [TIME_W-1:0] o_wait_time;
    logic [SUM_W-1:0] o_stat_value;
    logic [FILL_W-1:0] o_high_fill;
    logic [FILL_W-1:0] o_low_fill;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    two_class_priority_queue_arbiter_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .start(start), .busy(busy),
        .i_cmd(i_cmd), .i_entry_id(i_entry_id),
        .i_time_value(i_time_value), .i_stat_select(i_stat_select),
        .o_done(o_done), .o_status(o_status), .o_activity(o_activity),
        .o_served_id(o_served_id), .o_served_start(o_served_start),
        .o_wait_time(o_wait_time), .o_stat_value(o_stat_value),
        .o_high_fill(o_high_fill), .o_low_fill(o_low_fill),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Clock with a period of 20.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Bench bookkeeping.
    t_sched_cmd    cmd_backlog[$];
    t_sched_result expected_words[$];
    int            issued_total = 0;
    int            accepted_total = 0;
    int            err_count = 0;
    logic          took = 1'b0;
    logic          no_gaps = 1'b0;
    logic [TIME_W-1:0] traffic_clock = '0;

    // Predicted scheduler state; index 0 is the high class, 1 the low class.
    t_entry            q_store[2][QUEUE_DEPTH];
    logic [PTR_W-1:0]  q_head[2] = '{default: '0};
    logic [FILL_W-1:0] q_fill[2] = '{default: '0};
    logic [CNT_W-1:0]  evt_count[NUM_EVT] = '{default: '0};
    logic [SUM_W-1:0]  wait_sum[2] = '{default: '0};
    logic [CNT_W-1:0]  idle_count = '0;
    logic [FILL_W-1:0] limit_reg = LIMIT_RESET;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c == CNT_MAX) ? c : c + 1'b1;
    endfunction

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] s,
                                                 input logic [SUM_W-1:0] v);
        return (v >= SUM_MAX - s) ? SUM_MAX : s + v;
    endfunction

    // Advance the predicted state by one command and form its result word.
    task automatic schedule_step(input t_sched_cmd c, output t_sched_result r);
        int cls;
        logic [FILL_W-1:0] lim;
        logic [PTR_W-1:0] pos;
        t_entry e;
        r.status = 1'b0;
        r.act = ACT_IDLE;
        r.id = '0;
        r.srv_start = '0;
        r.wait_cycles = '0;
        r.stat = '0;
        lim = (limit_reg > QUEUE_DEPTH) ? FILL_W'(QUEUE_DEPTH) : limit_reg;
        case (c.cmd)
            CMD_ENQ_HIGH, CMD_ENQ_LOW: begin
                cls = (c.cmd == CMD_ENQ_HIGH) ? 0 : 1;
                evt_count[EVT_HIGH_REQ + cls] = sat_inc(evt_count[EVT_HIGH_REQ + cls]);
                if (q_fill[cls] >= lim) begin
                    // Tail drop.
                    r.status = 1'b1;
                    evt_count[EVT_HIGH_REF + cls] = sat_inc(evt_count[EVT_HIGH_REF + cls]);
                end else begin
                    pos = PTR_W'(q_head[cls] + q_fill[cls]);
                    q_store[cls][pos].id = c.id;
                    q_store[cls][pos].start = c.tval;
                    q_fill[cls] = q_fill[cls] + 1'b1;
                    evt_count[EVT_HIGH_ACC + cls] = sat_inc(evt_count[EVT_HIGH_ACC + cls]);
                end
            end
            CMD_SERVICE: begin
                // Strict priority: high first, then low, else an idle slot.
                cls = (q_fill[0] != 0) ? 0 : (q_fill[1] != 0) ? 1 : -1;
                if (cls < 0) begin
                    idle_count = sat_inc(idle_count);
                end else begin
                    e = q_store[cls][q_head[cls]];
                    q_head[cls] = q_head[cls] + 1'b1;
                    q_fill[cls] = q_fill[cls] - 1'b1;
                    r.id = e.id;
                    r.srv_start = e.start;
                    r.wait_cycles = c.tval - e.start;
                    wait_sum[cls] = sat_add(wait_sum[cls], SUM_W'(r.wait_cycles));
                    evt_count[EVT_HIGH_SRV + cls] = sat_inc(evt_count[EVT_HIGH_SRV + cls]);
                    r.act = (cls == 0) ? ACT_HIGH : ACT_LOW;
                end
            end
            default: begin
                if (c.sel < NUM_EVT) r.stat = SUM_W'(evt_count[c.sel]);
                else if (c.sel == STAT_HIGH_WSUM) r.stat = wait_sum[0];
                else if (c.sel == STAT_LOW_WSUM) r.stat = wait_sum[1];
                else if (c.sel == STAT_IDLE) r.stat = SUM_W'(idle_count);
            end
        endcase
        r.hi_fill = q_fill[0];
        r.lo_fill = q_fill[1];
    endtask

    task automatic flag_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] seen);
        err_count++;
        if (err_count <= 10)
            $display("mismatch on %s: expected %0h, got %0h", what, want, seen);
    endtask

    task automatic compare_word(input t_sched_result want, input t_sched_result seen);
        if (seen.status !== want.status) flag_mismatch("status", want.status, seen.status);
        if (seen.act !== want.act) flag_mismatch("activity", want.act, seen.act);
        if (seen.id !== want.id) flag_mismatch("served_id", want.id, seen.id);
        if (seen.srv_start !== want.srv_start)
            flag_mismatch("served_start", want.srv_start, seen.srv_start);
        if (seen.wait_cycles !== want.wait_cycles)
            flag_mismatch("wait_time", want.wait_cycles, seen.wait_cycles);
        if (seen.stat !== want.stat) flag_mismatch("stat_value", want.stat, seen.stat);
        if (seen.hi_fill !== want.hi_fill)
            flag_mismatch("high_fill", want.hi_fill, seen.hi_fill);
        if (seen.lo_fill !== want.lo_fill)
            flag_mismatch("low_fill", want.lo_fill, seen.lo_fill);
    endtask

    // Driver: retire the accepted word, then present the next one or a gap.
    always @(negedge i_clk) begin : cmd_driver
        t_sched_cmd nxt;
        if (took) nxt = cmd_backlog.pop_front();
        if (cmd_backlog.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 19)) begin
            nxt = cmd_backlog[0];
            start <= 1'b1;
            i_cmd <= nxt.cmd;
            i_entry_id <= nxt.id;
            i_time_value <= nxt.tval;
            i_stat_select <= nxt.sel;
        end else begin
            start <= 1'b0;
        end
    end

    // Monitor: check returning words, then predict for a word accepted now.
    always @(posedge i_clk) begin : result_monitor
        t_sched_result seen;
        t_sched_result want;
        t_sched_cmd cmd_now;
        if (i_rst_n && o_done) begin
            seen.status = o_status;
            seen.act = t_activity'(o_activity);
            seen.id = o_served_id;
            seen.srv_start = o_served_start;
            seen.wait_cycles = o_wait_time;
            seen.stat = o_stat_value;
            seen.hi_fill = o_high_fill;
            seen.lo_fill = o_low_fill;
            if (expected_words.size() == 0) begin
                flag_mismatch("unexpected word, served_id", 64'd0, seen.id);
            end else begin
                want = expected_words.pop_front();
                compare_word(want, seen);
            end
        end
        if (i_rst_n && start && !busy) begin
            cmd_now.cmd = t_cmd'(i_cmd);
            cmd_now.id = i_entry_id;
            cmd_now.tval = i_time_value;
            cmd_now.sel = i_stat_select;
            schedule_step(cmd_now, want);
            expected_words.push_back(want);
            accepted_total++;
        end
        took <= i_rst_n && start && !busy;
    end

    task automatic queue_cmd(input t_cmd c, input logic [ID_W-1:0] id,
                             input logic [TIME_W-1:0] tval, input logic [3:0] sel);
        t_sched_cmd w;
        w.cmd = c;
        w.id = id;
        w.tval = tval;
        w.sel = sel;
        cmd_backlog.push_back(w);
        issued_total++;
    endtask

    // Hold until every issued word has been accepted and answered.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (accepted_total != issued_total || expected_words.size() != 0);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic check_limit_readback();
        logic [31:0] got;
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= LIMIT_ADDR;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk);
        while (!pready);
        got = prdata;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (got !== 32'(limit_reg)) flag_mismatch("depth cap readback", limit_reg, got);
    endtask

    // Register write with junk above the field, then read it back.
    task automatic write_limit(input logic [FILL_W-1:0] value);
        logic [31:0] data;
        data = $urandom;
        data[FILL_W-1:0] = value;
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= LIMIT_ADDR;
        pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk);
        while (!pready);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        limit_reg = value;
        check_limit_readback();
    endtask

    // Bursts that lean toward filling, draining or neither, over a running clock.
    task automatic queue_random_traffic(input int n);
        int left_in_burst;
        int enq_cut;
        int hi_share;
        int roll;
        t_cmd c;
        logic [TIME_W-1:0] tval;
        left_in_burst = 0;
        enq_cut = 55;
        hi_share = 50;
        for (int k = 0; k < n; k++) begin
            if (left_in_burst == 0) begin
                left_in_burst = $urandom_range(8, 40);
                case ($urandom_range(0, 2))
                    0: enq_cut = 80;
                    1: enq_cut = 30;
                    default: enq_cut = 55;
                endcase
                hi_share = 20 + 30 * $urandom_range(0, 2);
            end
            left_in_burst--;
            roll = $urandom_range(0, 99);
            if (roll < 10) c = CMD_READ;
            else if (roll < enq_cut)
                c = ($urandom_range(0, 99) < hi_share) ? CMD_ENQ_HIGH : CMD_ENQ_LOW;
            else c = CMD_SERVICE;
            traffic_clock = traffic_clock + $urandom_range(0, 50);
            if ($urandom_range(0, 199) == 0) traffic_clock = $urandom;
            tval = ($urandom_range(0, 15) == 0) ? TIME_W'($urandom) : traffic_clock;
            queue_cmd(c, ID_W'($urandom), tval, 4'($urandom_range(0, 15)));
        end
    endtask

    // Stimulus sequence.
    initial begin : stimulus
        logic [FILL_W-1:0] random_limits[5];
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        check_limit_readback();

        // Directed: field extremes, wraparound waits, empty service, odd selects.
        @(posedge i_clk);
        queue_cmd(CMD_READ, '0, '0, 4'd0);
        queue_cmd(CMD_READ, '1, '1, 4'd15);
        queue_cmd(CMD_SERVICE, '0, '0, 4'd3);
        queue_cmd(CMD_ENQ_HIGH, '0, '0, 4'd0);
        queue_cmd(CMD_ENQ_HIGH, '1, '1, 4'd15);
        queue_cmd(CMD_ENQ_LOW, 16'h5AA5, 32'd100, 4'd7);
        queue_cmd(CMD_SERVICE, 16'h1234, '1, 4'd0);
        queue_cmd(CMD_SERVICE, 16'h0, 32'd5, 4'd0);
        queue_cmd(CMD_SERVICE, 16'h0, 32'd0, 4'd0);
        queue_cmd(CMD_SERVICE, 16'hFFFF, '1, 4'd12);
        queue_cmd(CMD_READ, '0, '0, 4'd2);
        queue_cmd(CMD_READ, '0, '0, 4'd3);
        queue_cmd(CMD_READ, '0, '0, 4'd4);
        queue_cmd(CMD_READ, '0, '0, 4'd6);
        queue_cmd(CMD_READ, '0, '0, 4'd7);
        queue_cmd(CMD_READ, '0, '0, STAT_HIGH_WSUM);
        queue_cmd(CMD_READ, '0, '0, STAT_LOW_WSUM);
        queue_cmd(CMD_READ, '0, '0, STAT_IDLE);
        queue_cmd(CMD_READ, '0, '0, 4'd11);
        queue_cmd(CMD_READ, '1, '1, 4'd14);
        wait_drained();

        // Limit above the depth acts as the depth: overfill both queues.
        write_limit(5'd31);
        @(posedge i_clk);
        for (int k = 0; k < 18; k++)
            queue_cmd(CMD_ENQ_HIGH, ID_W'($urandom), TIME_W'(1000 + k), 4'($urandom));
        for (int k = 0; k < 18; k++)
            queue_cmd(CMD_ENQ_LOW, ID_W'($urandom), TIME_W'(2000 + k), 4'($urandom));
        queue_cmd(CMD_READ, '0, '0, 4'd4);
        queue_cmd(CMD_READ, '0, '0, 4'd5);
        for (int k = 0; k < 34; k++)
            queue_cmd(CMD_SERVICE, ID_W'($urandom), TIME_W'(3000 + 7 * k), 4'($urandom));
        queue_cmd(CMD_READ, '0, '0, STAT_HIGH_WSUM);
        queue_cmd(CMD_READ, '0, '0, STAT_LOW_WSUM);
        wait_drained();

        // Limit zero refuses every enqueue.
        write_limit(5'd0);
        @(posedge i_clk);
        for (int k = 0; k < 3; k++) begin
            queue_cmd(CMD_ENQ_HIGH, ID_W'($urandom), $urandom, 4'($urandom));
            queue_cmd(CMD_ENQ_LOW, ID_W'($urandom), $urandom, 4'($urandom));
        end
        queue_cmd(CMD_SERVICE, '0, $urandom, 4'd0);
        queue_cmd(CMD_READ, '0, '0, 4'd4);
        queue_cmd(CMD_READ, '0, '0, 4'd5);
        wait_drained();

        // Single-entry queues.
        write_limit(5'd1);
        @(posedge i_clk);
        queue_cmd(CMD_ENQ_HIGH, 16'h0001, 32'd10, 4'd0);
        queue_cmd(CMD_ENQ_HIGH, 16'h0002, 32'd11, 4'd0);
        queue_cmd(CMD_ENQ_LOW, 16'h0003, 32'd12, 4'd0);
        queue_cmd(CMD_ENQ_LOW, 16'h0004, 32'd13, 4'd0);
        repeat (3) queue_cmd(CMD_SERVICE, '0, 32'd50, 4'd0);
        queue_cmd(CMD_READ, '0, '0, STAT_IDLE);
        wait_drained();

        // Random traffic under several limits; one phase runs with no gaps.
        random_limits[0] = 5'd16;
        random_limits[1] = 5'd17;
        random_limits[2] = FILL_W'($urandom_range(2, 15));
        random_limits[3] = FILL_W'($urandom_range(0, 31));
        random_limits[4] = FILL_W'($urandom_range(2, 8));
        for (int ph = 0; ph < 5; ph++) begin
            write_limit(random_limits[ph]);
            @(posedge i_clk);
            no_gaps = (ph == 2);
            queue_random_traffic(270);
            wait_drained();
        end

        repeat (5) @(negedge i_clk);
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #4000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

/* files.f */
sv/tcpqa_pkg.sv
sv/two_class_priority_queue_arbiter_top.sv
test/two_class_priority_queue_arbiter_top_tb.sv
